[src/sto_pkg.sv]
// shared types, codes and defaults for the status triangle overlay
// no dependencies; imported by every module of the block
package sto_pkg;

    localparam int HResDefault = 720;
    localparam int VResDefault = 720;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_SUCCESS  = 3'd2;
    localparam logic [2:0] KIND_FAIL     = 3'd3;
    localparam logic [2:0] KIND_FAIL_IFP = 3'd4;
    localparam logic [2:0] KIND_PIXEL    = 3'd5;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_PROC = 2'd1;
    localparam logic [1:0] MODE_FAIL = 2'd2;

    localparam logic [2:0] CFG_ENABLED  = 3'd0;
    localparam logic [2:0] CFG_TRI_SIZE = 3'd1;
    localparam logic [2:0] CFG_ROTATION = 3'd2;
    localparam logic [2:0] CFG_WATCHDOG = 3'd3;
    localparam logic [2:0] CFG_FAIL_SHOW = 3'd4;

    localparam logic [8:0]  TRI_SIZE_MIN     = 9'd16;
    localparam logic [8:0]  TRI_SIZE_MAX     = 9'd256;
    localparam logic [8:0]  TRI_SIZE_RESET   = 9'd64;
    localparam logic [15:0] WATCHDOG_RESET   = 16'd30000;
    localparam logic [15:0] FAIL_SHOW_RESET  = 16'd3000;
    localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

    localparam logic [23:0] COLOR_BLUE = 24'h0000FF;
    localparam logic [23:0] COLOR_RED  = 24'hFF0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [23:0] pixel_in;
    } sto_in_t;

    typedef struct packed {
        logic [23:0] pixel_out;
        logic        overlay_hit;
        logic [1:0]  shown_mode;
    } sto_out_t;

    // indicator status seen by the painter
    typedef struct packed {
        logic       active;
        logic [1:0] mode;
    } sto_status_t;

endpackage

[src/sto_state.sv]
// indicator state machine: mode and saturating millisecond count
// depends on sto_pkg
module sto_state
    import sto_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [2:0]  kind,
    input  logic        active,
    input  logic [15:0] watchdog_ms,
    input  logic [15:0] fail_show_ms,
    output sto_status_t status
);

    logic [1:0]  mode_reg, mode_next, mode_eff;
    logic [15:0] elapsed_reg, elapsed_next, elapsed_eff, elapsed_inc;

    // inactive forces idle before the word is applied
    assign mode_eff    = active ? mode_reg : MODE_IDLE;
    assign elapsed_eff = active ? elapsed_reg : 16'd0;
    assign elapsed_inc = (elapsed_eff == ELAPSED_MAX) ? elapsed_eff : elapsed_eff + 16'd1;

    assign status.active = active;
    assign status.mode   = mode_eff;

    always_comb
    begin
        mode_next    = mode_eff;
        elapsed_next = elapsed_eff;
        if (active)
        begin
            case (kind)
                KIND_TICK:
                begin
                    if (mode_eff == MODE_PROC)
                    begin
                        if (elapsed_inc > watchdog_ms)
                        begin
                            mode_next    = MODE_FAIL;
                            elapsed_next = 16'd0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    else if (mode_eff != MODE_IDLE)
                    begin
                        if (elapsed_inc > fail_show_ms)
                        begin
                            mode_next    = MODE_IDLE;
                            elapsed_next = 16'd0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                end
                KIND_START:
                begin
                    if (mode_eff != MODE_PROC)
                    begin
                        mode_next    = MODE_PROC;
                        elapsed_next = 16'd0;
                    end
                end
                KIND_SUCCESS:
                begin
                    mode_next    = MODE_IDLE;
                    elapsed_next = 16'd0;
                end
                KIND_FAIL:
                begin
                    mode_next    = MODE_FAIL;
                    elapsed_next = 16'd0;
                end
                KIND_FAIL_IFP:
                begin
                    if (mode_eff == MODE_PROC)
                    begin
                        mode_next    = MODE_FAIL;
                        elapsed_next = 16'd0;
                    end
                end
                default:
                begin
                    mode_next    = mode_eff;
                    elapsed_next = elapsed_eff;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            elapsed_reg <= 16'd0;
        end
        else if (go)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

[src/sto_paint.sv]
// triangle hit test and color overlay for one pixel word
// depends on sto_pkg
module sto_paint
    import sto_pkg::*;
#(
    parameter int H_RES = HResDefault,
    parameter int V_RES = VResDefault
)
(
    input  sto_in_t     in_word,
    input  sto_status_t status,
    input  logic [8:0]  tri_n,
    input  logic [1:0]  rotation,
    output sto_out_t    out_word
);

    logic signed [13:0] lx, ly, n_s, sum;
    logic               on_screen, in_box, in_tri, drawing;

    assign n_s = $signed({5'd0, tri_n});
    assign on_screen = ({1'b0, in_word.pos_x} < 13'(H_RES)) &&
                       ({1'b0, in_word.pos_y} < 13'(V_RES));

    // local coordinates inside the rotated corner
    always_comb
    begin
        if (rotation == 2'd0 || rotation == 2'd3)
            lx = $signed({2'd0, in_word.pos_x}) - $signed(14'(H_RES)) + n_s;
        else
            lx = n_s - 14'sd1 - $signed({2'd0, in_word.pos_x});
        if (rotation == 2'd0 || rotation == 2'd1)
            ly = $signed({2'd0, in_word.pos_y}) - $signed(14'(V_RES)) + n_s;
        else
            ly = n_s - 14'sd1 - $signed({2'd0, in_word.pos_y});
    end

    assign sum    = lx + ly;
    assign in_box = (lx >= 14'sd0) && (lx < n_s) && (ly >= 14'sd0) && (ly < n_s);
    // lower-right half plus checkerboard
    assign in_tri = on_screen && in_box && (sum >= n_s - 14'sd1) && !sum[0];

    assign drawing = status.active && in_tri &&
                     (status.mode == MODE_PROC || status.mode == MODE_FAIL);

    always_comb
    begin
        out_word.pixel_out   = in_word.pixel_in;
        out_word.overlay_hit = drawing;
        out_word.shown_mode  = status.mode;
        if (drawing)
            out_word.pixel_out = (status.mode == MODE_PROC) ? COLOR_BLUE : COLOR_RED;
    end

endmodule

[src/status_triangle_overlay.sv]
// status triangle overlay top level: config registers, input and output stages
// depends on sto_pkg, sto_state, sto_paint
// a pixel word passes through the input stage register and then the output stage register
// throughput: one word per cycle while the output is not stalled
// events and ticks update the indicator and produce no output word
// reset: indicator idle, count zero, registers at their defaults, both stages empty
module status_triangle_overlay
    import sto_pkg::*;
#(
    parameter int H_RES = HResDefault,
    parameter int V_RES = VResDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  sto_in_t     in_word,
    // output words
    output logic        out_valid,
    input  logic        out_stall,
    output sto_out_t    out_word
);

    // configuration registers
    logic        enabled_reg;
    logic [8:0]  tri_size_reg;
    logic [1:0]  rotation_reg;
    logic [15:0] watchdog_reg;
    logic [15:0] fail_show_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            tri_size_reg  <= TRI_SIZE_RESET;
            rotation_reg  <= 2'd0;
            watchdog_reg  <= WATCHDOG_RESET;
            fail_show_reg <= FAIL_SHOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ENABLED:   enabled_reg   <= cfg_data[0];
                CFG_TRI_SIZE:  tri_size_reg  <= cfg_data[8:0];
                CFG_ROTATION:  rotation_reg  <= cfg_data[1:0];
                CFG_WATCHDOG:  watchdog_reg  <= cfg_data;
                CFG_FAIL_SHOW: fail_show_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // effective size: zero disables, otherwise clamp to 16..256
    logic [8:0] tri_n;
    logic       active;

    always_comb
    begin
        if (tri_size_reg == 9'd0)
            tri_n = 9'd0;
        else if (tri_size_reg < TRI_SIZE_MIN)
            tri_n = TRI_SIZE_MIN;
        else if (tri_size_reg > TRI_SIZE_MAX)
            tri_n = TRI_SIZE_MAX;
        else
            tri_n = tri_size_reg;
    end

    assign active = enabled_reg && (tri_n != 9'd0);

    // input stage
    logic        s0_valid_reg;
    sto_in_t     s0_word_reg;
    logic        s0_pixel, s0_go, out_free;

    // output stage
    logic        out_valid_reg;
    sto_out_t    out_word_reg;
    sto_out_t    paint_word;
    sto_status_t status;

    assign out_free = !out_valid_reg || !out_stall;
    assign s0_pixel = (s0_word_reg.kind == KIND_PIXEL);
    // non-pixel words retire at once; pixel words need the output slot
    assign s0_go    = s0_valid_reg && (!s0_pixel || out_free);
    assign in_stall = s0_valid_reg && !s0_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (!in_stall)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s0_word_reg <= in_word;
    end

    sto_state u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (s0_go),
        .kind         (s0_word_reg.kind),
        .active       (active),
        .watchdog_ms  (watchdog_reg),
        .fail_show_ms (fail_show_reg),
        .status       (status)
    );

    sto_paint #(
        .H_RES (H_RES),
        .V_RES (V_RES)
    ) u_paint (
        .in_word  (s0_word_reg),
        .status   (status),
        .tri_n    (tri_n),
        .rotation (rotation_reg),
        .out_word (paint_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s0_go && s0_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s0_go && s0_pixel)
            out_word_reg <= paint_word;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
